/* hdl/wbps_pkg.sv */
package wbps_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int OFS_W       = 32;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_OCCURRENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT       = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] idx;
    logic [7:0]       value;
    logic             wild;
    logic             scan;
    logic             last;
    logic [7:0]       data;
  } wbps_ctl_t;

endpackage

/* hdl/wbps_if.sv */
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] entry_index;
  logic [7:0] entry_value;
  logic       entry_wildcard;
  logic [7:0] scan_byte;
  logic       scan_last;

  modport source (output valid, kind, entry_index, entry_value, entry_wildcard,
                  scan_byte, scan_last, input ready);
  modport sink (input valid, kind, entry_index, entry_value, entry_wildcard,
                scan_byte, scan_last, output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;
  logic [31:0] hit_count;

  modport source (output valid, found, match_offset, hit_count, input ready);
  modport sink (input valid, found, match_offset, hit_count, output ready);
endinterface

/* hdl/wbps_cell.sv */
module wbps_cell
  import wbps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  wbps_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_id,
  input  logic             en,
  input  logic             prev_in,
  output logic             match_o,
  output logic             partial_o
);

  logic [7:0] pat_r;
  logic       wild_r;
  logic       partial_r;

  always_comb begin
    match_o = prev_in & en & (wild_r | (pat_r == ctl.data));
  end

  assign partial_o = partial_r;

  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.idx == cell_id)) begin
      pat_r  <= ctl.value;
      wild_r <= ctl.wild;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 1'b0;
    end else if (ctl.scan) begin
      partial_r <= ctl.last ? 1'b0 : match_o;
    end
  end

endmodule

/* hdl/wbps_tally.sv */
module wbps_tally
  import wbps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             hit,
  input  logic             last,
  input  logic [IDX_W-1:0] lenm1,
  input  logic [CNT_W-1:0] target_occ,
  input  logic [CNT_W-1:0] count_limit,
  input  logic             advance,
  wbps_out_if.source       out_ch
);

  logic [OFS_W-1:0] pos_r;
  logic [CNT_W-1:0] seen_r;
  logic [CNT_W-1:0] lim_r;
  logic             tfound_r;
  logic [OFS_W-1:0] toff_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic [31:0]      out_offset_r;
  logic [31:0]      out_count_r;

  logic             take;
  logic             found_nxt;
  logic [OFS_W-1:0] toff_nxt;
  logic [CNT_W-1:0] seen_nxt;
  logic [CNT_W-1:0] lim_nxt;

  always_comb begin
    take      = hit && !tfound_r && (seen_r == target_occ);
    found_nxt = tfound_r | take;
    toff_nxt  = take ? (pos_r - OFS_W'(lenm1)) : toff_r;
    seen_nxt  = (hit && (seen_r != {CNT_W{1'b1}})) ? seen_r + 1'b1 : seen_r;
    lim_nxt   = (hit && (lim_r < count_limit)) ? lim_r + 1'b1 : lim_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      seen_r      <= '0;
      lim_r       <= '0;
      tfound_r    <= 1'b0;
      toff_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step && advance && last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (step && advance) begin
        if (last) begin
          pos_r    <= '0;
          seen_r   <= '0;
          lim_r    <= '0;
          tfound_r <= 1'b0;
          toff_r   <= '0;
        end else begin
          pos_r    <= pos_r + 1'b1;
          seen_r   <= seen_nxt;
          lim_r    <= lim_nxt;
          tfound_r <= found_nxt;
          toff_r   <= toff_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && advance && last) begin
      out_found_r  <= found_nxt;
      out_offset_r <= found_nxt ? toff_nxt[31:0] : 32'd0;
      out_count_r  <= lim_nxt[31:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.match_offset = out_offset_r;
  assign out_ch.hit_count    = out_count_r;

endmodule

/* hdl/wildcard_byte_pattern_scanner_core.sv */
// channel  | dir | handshake           | payload
// in_ch    | in  | valid/ready         | kind, entry_*, scan_byte, scan_last
// out_ch   | out | valid/ready         | found, match_offset, hit_count
// cfg      | in  | cfg_we, no wait     | cfg_index, cfg_wdata
// One beat per cycle unless out_ch stalls. The cell row matches a byte in the
// accept cycle; s1 registers the hit and the tally stage registers the result.
// Synchronous active-low reset clears the chain and counters and resets the
// config. A stalled result holds in_ch.ready low until out_ch takes it.
module wildcard_byte_pattern_scanner_core
  import wbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  wbps_in_if.sink              in_ch,
  wbps_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [LEN_W-1:0] pattern_length_r;
  logic [CNT_W-1:0] target_occ_r;
  logic [CNT_W-1:0] count_limit_r;

  logic             s1_valid_r;
  logic             s1_hit_r;
  logic             s1_last_r;
  logic [IDX_W-1:0] s1_lenm1_r;

  logic                   advance;
  logic                   in_take;
  logic [LEN_W-1:0]       len_eff;
  logic [IDX_W-1:0]       lenm1;
  logic                   hit;
  wbps_ctl_t              ctl;
  logic [PATTERN_MAX-1:0] match_v;
  logic [PATTERN_MAX-1:0] partial_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      target_occ_r     <= '0;
      count_limit_r    <= {CNT_W{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH:    pattern_length_r <= cfg_wdata[LEN_W-1:0];
        REG_TARGET_OCCURRENCE: target_occ_r     <= cfg_wdata[CNT_W-1:0];
        REG_COUNT_LIMIT:       count_limit_r    <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;
  assign in_take     = in_ch.valid && advance;

  always_comb begin
    len_eff = (pattern_length_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                      : pattern_length_r;
    lenm1   = IDX_W'(len_eff - 1'b1);
    hit     = (len_eff != '0) && match_v[lenm1];

    ctl.load  = in_take && (in_ch.kind == KIND_LOAD);
    ctl.idx   = in_ch.entry_index[IDX_W-1:0];
    ctl.value = in_ch.entry_value;
    ctl.wild  = in_ch.entry_wildcard;
    ctl.scan  = in_take && (in_ch.kind == KIND_SCAN);
    ctl.last  = in_ch.scan_last;
    ctl.data  = in_ch.scan_byte;
  end

  for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
    logic prev;
    if (gi == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = partial_v[gi-1];
    end
    wbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cell_id   (IDX_W'(gi)),
      .en        (LEN_W'(gi) < len_eff),
      .prev_in   (prev),
      .match_o   (match_v[gi]),
      .partial_o (partial_v[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= ctl.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_hit_r   <= hit;
      s1_last_r  <= in_ch.scan_last;
      s1_lenm1_r <= lenm1;
    end
  end

  wbps_tally u_tally (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_valid_r),
    .hit         (s1_hit_r),
    .last        (s1_last_r),
    .lenm1       (s1_lenm1_r),
    .target_occ  (target_occ_r),
    .count_limit (count_limit_r),
    .advance     (advance),
    .out_ch      (out_ch)
  );

`ifndef ASSERT_OFF
  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(s1_valid_r && s1_last_r))
    else $error("result without a last scan beat");

  a_chain_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.scan && ctl.last) |=> (partial_v == '0))
    else $error("chain not cleared after last beat");

  a_zero_len_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (len_eff == '0) |-> (match_v == '0))
    else $error("match with zero pattern length");
`endif

endmodule
